[rtl/bpru_pkg.sv]
// bpru_pkg: shared widths, register indexes, format codes and the pixel type
// for the bitmap pixel row unpacker; no dependencies
package bpru_pkg;

   localparam int DIM_BITS_DEF = 16;
   localparam int BYTE_W       = 8;
   localparam int OUT_DIM_W    = 16;
   localparam int BPP_W        = 3;
   localparam int CSR_IDX_W    = 2;
   localparam int CSR_DATA_W   = 16;

   localparam logic [BYTE_W-1:0] OPAQUE = 8'hFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_BPP    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HEIGHT = 2'd2;

   // last byte index of a pixel, one code per stored format
   localparam logic [1:0] FMT_GRAY  = 2'd0;
   localparam logic [1:0] FMT_GRAYA = 2'd1;
   localparam logic [1:0] FMT_BGR   = 2'd2;
   localparam logic [1:0] FMT_BGRA  = 2'd3;

   typedef struct packed {
      logic [BYTE_W-1:0]    red;
      logic [BYTE_W-1:0]    green;
      logic [BYTE_W-1:0]    blue;
      logic [BYTE_W-1:0]    alpha;
      logic [OUT_DIM_W-1:0] pixel_column;
      logic [OUT_DIM_W-1:0] pixel_row;
      logic                 image_done;
   } pixel_type;

endpackage

[rtl/bpru_if.sv]
// bpru channel interfaces: byte input, pixel output and register write port
// depends on bpru_pkg
interface bpru_req_if import bpru_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink   (input valid, input data_byte, output ready);
endinterface

interface bpru_rsp_if import bpru_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [BYTE_W-1:0]    red;
   logic [BYTE_W-1:0]    green;
   logic [BYTE_W-1:0]    blue;
   logic [BYTE_W-1:0]    alpha;
   logic [OUT_DIM_W-1:0] pixel_column;
   logic [OUT_DIM_W-1:0] pixel_row;
   logic                 image_done;

   modport source (output valid, output red, output green, output blue, output alpha,
                   output pixel_column, output pixel_row, output image_done,
                   input ready);
   modport sink   (input valid, input red, input green, input blue, input alpha,
                   input pixel_column, input pixel_row, input image_done,
                   output ready);
endinterface

interface bpru_csr_if import bpru_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/bmp_pixel_row_unpacker.sv]
// bmp_pixel_row_unpacker: bitmap pixel-data bytes in, RGBA pixels with position out
// depends on bpru_pkg and the interfaces in bpru_if
//
//   channel    dir   payload                                          transfer
//   req_chan   in    data_byte                                        valid & ready
//   rsp_chan   out   red green blue alpha pixel_column pixel_row      valid & ready
//                    image_done
//   csr_chan   in    index data                                       valid & ready
//
// one byte per cycle while req_chan.ready is high; a byte's decode and counter update
// is one combinational pass into the output register, so a pixel is offered in the cycle after its last byte
// reset loads bytes_per_pixel 3, width 1, height 1 and clears all counters
// req_chan.ready drops only while a pixel waits in the output register and
// rsp_chan.ready is low; csr_chan is always ready
module bmp_pixel_row_unpacker import bpru_pkg::*; #(
   parameter int DIM_BITS = DIM_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   bpru_req_if.sink   req_chan,
   bpru_rsp_if.source rsp_chan,
   bpru_csr_if.sink   csr_chan
);

   logic [BPP_W-1:0]    bpp_ff;
   logic [DIM_BITS-1:0] width_ff, height_ff;

   logic [1:0]          idx_ff, idx_in;
   logic [BYTE_W-1:0]   held_first_ff, held_first_in;
   logic [BYTE_W-1:0]   held_second_ff, held_second_in;
   logic [BYTE_W-1:0]   held_third_ff, held_third_in;
   logic [DIM_BITS-1:0] col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;
   logic [1:0]          pad_ff, pad_in;
   logic                rsp_valid_ff, rsp_valid_in;
   pixel_type           pix_ff, pix_in;

   logic                req_take;
   logic [1:0]          last_idx;
   logic [DIM_BITS-1:0] w_eff, h_eff;
   logic                last_col, last_row;
   logic [4:0]          rem_prod;
   logic [BYTE_W-1:0]   b;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign b              = req_chan.data_byte;

   always_comb begin
      if (bpp_ff == 3'd0) begin
         last_idx = FMT_GRAY;
      end else if (bpp_ff inside {[3'd1:3'd4]}) begin
         last_idx = bpp_ff[1:0] - 2'd1;
      end else begin
         last_idx = FMT_BGRA;
      end
   end

   assign w_eff    = (width_ff == '0) ? DIM_BITS'(1) : width_ff;
   assign h_eff    = (height_ff == '0) ? DIM_BITS'(1) : height_ff;
   assign last_col = col_ff >= (w_eff - DIM_BITS'(1));
   assign last_row = row_ff >= (h_eff - DIM_BITS'(1));
   assign rem_prod = 5'(w_eff[1:0]) * 5'({1'b0, last_idx} + 3'd1);

   always_comb begin
      idx_in         = idx_ff;
      held_first_in  = held_first_ff;
      held_second_in = held_second_ff;
      held_third_in  = held_third_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      pad_in         = pad_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      pix_in         = pix_ff;

      if (req_take) begin
         if (pad_ff != 2'd0) begin
            pad_in = pad_ff - 2'd1;
         end else if (idx_ff < last_idx) begin
            case (idx_ff)
               2'd0:    held_first_in  = b;
               2'd1:    held_second_in = b;
               default: held_third_in  = b;
            endcase
            idx_in = idx_ff + 2'd1;
         end else begin
            pix_in.alpha = OPAQUE;
            case (last_idx)
               FMT_GRAY: begin
                  pix_in.red   = b;
                  pix_in.green = b;
                  pix_in.blue  = b;
               end
               FMT_GRAYA: begin
                  pix_in.red   = held_first_ff;
                  pix_in.green = held_first_ff;
                  pix_in.blue  = held_first_ff;
                  pix_in.alpha = b;
               end
               FMT_BGR: begin
                  pix_in.blue  = held_first_ff;
                  pix_in.green = held_second_ff;
                  pix_in.red   = b;
               end
               default: begin
                  pix_in.blue  = held_first_ff;
                  pix_in.green = held_second_ff;
                  pix_in.red   = held_third_ff;
                  pix_in.alpha = b;
               end
            endcase
            pix_in.pixel_column = OUT_DIM_W'(col_ff);
            pix_in.pixel_row    = OUT_DIM_W'(row_ff);
            pix_in.image_done   = last_col && last_row;
            rsp_valid_in        = 1'b1;
            idx_in              = 2'd0;

            if (last_col) begin
               pad_in = 2'd0 - rem_prod[1:0];
               col_in = '0;
               row_in = last_row ? '0 : row_ff + DIM_BITS'(1);
            end else begin
               col_in = col_ff + DIM_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff         <= 3'd3;
         width_ff       <= DIM_BITS'(1);
         height_ff      <= DIM_BITS'(1);
         idx_ff         <= 2'd0;
         held_first_ff  <= '0;
         held_second_ff <= '0;
         held_third_ff  <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         pad_ff         <= 2'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         idx_ff         <= idx_in;
         held_first_ff  <= held_first_in;
         held_second_ff <= held_second_in;
         held_third_ff  <= held_third_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         pad_ff         <= pad_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_chan.valid && csr_chan.ready) begin
            case (csr_chan.index)
               CSR_BPP:    bpp_ff    <= csr_chan.data[BPP_W-1:0];
               CSR_WIDTH:  width_ff  <= csr_chan.data[DIM_BITS-1:0];
               CSR_HEIGHT: height_ff <= csr_chan.data[DIM_BITS-1:0];
               default:    ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      pix_ff <= pix_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.red          = pix_ff.red;
   assign rsp_chan.green        = pix_ff.green;
   assign rsp_chan.blue         = pix_ff.blue;
   assign rsp_chan.alpha        = pix_ff.alpha;
   assign rsp_chan.pixel_column = pix_ff.pixel_column;
   assign rsp_chan.pixel_row    = pix_ff.pixel_row;
   assign rsp_chan.image_done   = pix_ff.image_done;

endmodule

[dv/bpru_pixel_checker.sv]
`timescale 1ns / 100ps
// bpru_pixel_checker: watches the byte, pixel and register channels of the bitmap row
// unpacker, predicts each pixel and compares it; depends on bpru_pkg and bpru_if
module bpru_pixel_checker import bpru_pkg::*; (
   input  logic clock,
   input  logic reset,
   bpru_req_if  req_mon,
   bpru_rsp_if  rsp_mon,
   bpru_csr_if  csr_mon,
   output int   fail_count,
   output int   pending
);

   logic [BPP_W-1:0]      fmt_code;
   logic [CSR_DATA_W-1:0] width_reg;
   logic [CSR_DATA_W-1:0] height_reg;

   logic [1:0]            byte_idx;
   logic [BYTE_W-1:0]     first_b;
   logic [BYTE_W-1:0]     second_b;
   logic [BYTE_W-1:0]     third_b;
   logic [OUT_DIM_W-1:0]  col_cnt;
   logic [OUT_DIM_W-1:0]  row_cnt;
   logic [1:0]            pad_cnt;

   pixel_type             expected_pixels [$];

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         fail_count++;
      end
   endtask

   task automatic unpack_byte(input logic [BYTE_W-1:0] b);
      logic [1:0]           last_idx;
      logic [OUT_DIM_W-1:0] w_eff;
      logic [OUT_DIM_W-1:0] h_eff;
      logic [3:0]           row_rem;
      logic                 last_col;
      logic                 last_row;
      pixel_type            px;
      // padding at the end of a row is swallowed
      if (pad_cnt != 2'd0) begin
         pad_cnt = pad_cnt - 2'd1;
         return;
      end
      if (fmt_code == 3'd0) begin
         last_idx = FMT_GRAY;
      end else if (fmt_code > 3'd4) begin
         last_idx = FMT_BGRA;
      end else begin
         last_idx = 2'(fmt_code - 3'd1);
      end
      if (byte_idx < last_idx) begin
         case (byte_idx)
            2'd0:    first_b = b;
            2'd1:    second_b = b;
            default: third_b = b;
         endcase
         byte_idx = byte_idx + 2'd1;
         return;
      end
      px.alpha = OPAQUE;
      case (last_idx)
         FMT_GRAY: begin
            px.red = b;
            px.green = b;
            px.blue = b;
         end
         FMT_GRAYA: begin
            px.red = first_b;
            px.green = first_b;
            px.blue = first_b;
            px.alpha = b;
         end
         FMT_BGR: begin
            px.blue = first_b;
            px.green = second_b;
            px.red = b;
         end
         default: begin
            px.blue = first_b;
            px.green = second_b;
            px.red = third_b;
            px.alpha = b;
         end
      endcase
      byte_idx = 2'd0;
      w_eff = (width_reg == '0) ? 16'd1 : width_reg;
      h_eff = (height_reg == '0) ? 16'd1 : height_reg;
      last_col = col_cnt >= w_eff - 16'd1;
      last_row = row_cnt >= h_eff - 16'd1;
      px.pixel_column = col_cnt;
      px.pixel_row = row_cnt;
      px.image_done = last_col && last_row;
      expected_pixels.push_back(px);
      if (last_col) begin
         row_rem = {2'b00, w_eff[1:0]} * ({2'b00, last_idx} + 4'd1);
         pad_cnt = 2'd0 - row_rem[1:0];
         col_cnt = '0;
         row_cnt = last_row ? '0 : row_cnt + 16'd1;
      end else begin
         col_cnt = col_cnt + 16'd1;
      end
   endtask

   always @(posedge clock) begin
      pixel_type want;
      if (reset) begin
         fmt_code = 3'd3;
         width_reg = 16'd1;
         height_reg = 16'd1;
         byte_idx = '0;
         first_b = '0;
         second_b = '0;
         third_b = '0;
         col_cnt = '0;
         row_cnt = '0;
         pad_cnt = '0;
         expected_pixels.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_pixels.size() == 0) begin
               $display("%0t: pixel transfer with none expected, got col %0d row %0d",
                        $time, rsp_mon.pixel_column, rsp_mon.pixel_row);
               fail_count++;
            end else begin
               want = expected_pixels.pop_front();
               check_field("red", want.red, rsp_mon.red);
               check_field("green", want.green, rsp_mon.green);
               check_field("blue", want.blue, rsp_mon.blue);
               check_field("alpha", want.alpha, rsp_mon.alpha);
               check_field("pixel_column", want.pixel_column, rsp_mon.pixel_column);
               check_field("pixel_row", want.pixel_row, rsp_mon.pixel_row);
               check_field("image_done", want.image_done, rsp_mon.image_done);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            unpack_byte(req_mon.data_byte);
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_BPP:    fmt_code = csr_mon.data[BPP_W-1:0];
               CSR_WIDTH:  width_reg = csr_mon.data;
               CSR_HEIGHT: height_reg = csr_mon.data;
               default: ;
            endcase
         end
      end
      pending = expected_pixels.size();
   end

endmodule

[dv/tb_bmp_pixel_row_unpacker.sv]
`timescale 1ns / 100ps
// tb_bmp_pixel_row_unpacker: drives bitmap bytes and register writes into the unpacker
// with random gaps and output stalls; depends on bpru_pkg, bpru_if and bpru_pixel_checker
module tb_bmp_pixel_row_unpacker;
   import bpru_pkg::*;

   localparam logic [BYTE_W-1:0] DIRECTED_BYTES [25] = '{
      8'h00, 8'hFF, 8'h5A, 8'hA5,
      8'hFF, 8'h00, 8'h11, 8'h22,
      8'h80, 8'h7F, 8'h01, 8'hFE, 8'hC3, 8'h3C, 8'h55, 8'hAA,
      8'h12, 8'h34, 8'h56, 8'h78, 8'h9A, 8'hBC,
      8'hDE, 8'hF0, 8'h0F
   };

   logic clock = 1'b0;
   logic reset;
   int   fail_count;
   int   exp_pending;
   logic calm;
   int   dir_pos;
   int   cur_fmt;
   int   cur_w;
   int   cur_h;

   bpru_req_if req_chan ();
   bpru_rsp_if rsp_chan ();
   bpru_csr_if csr_chan ();

   bmp_pixel_row_unpacker u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   bpru_pixel_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_mon    (csr_chan),
      .fail_count (fail_count),
      .pending    (exp_pending)
   );

   always #4 clock = ~clock;

   initial begin
      #2_000_000;
      $display("bmp_pixel_row_unpacker test failed");
      $finish;
   end

   // output side stalls in random bursts
   initial begin
      int stall_left;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   task automatic push_byte(input logic [BYTE_W-1:0] b);
      req_chan.valid <= 1'b1;
      req_chan.data_byte <= b;
      do @(negedge clock); while (!req_chan.ready);
      @(posedge clock);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_chan.valid <= 1'b1;
      csr_chan.index <= idx;
      csr_chan.data <= value;
      do @(negedge clock); while (!csr_chan.ready);
      @(posedge clock);
   endtask

   task automatic program_regs(input int fmt, input int w, input int h, input logic [2:0] sel);
      if (sel[0]) begin
         write_reg(CSR_BPP, CSR_DATA_W'(fmt));
         cur_fmt = fmt;
      end
      if (sel[1]) begin
         write_reg(CSR_WIDTH, CSR_DATA_W'(w));
         cur_w = w;
      end
      if (sel[2]) begin
         write_reg(CSR_HEIGHT, CSR_DATA_W'(h));
         cur_h = h;
      end
      csr_chan.valid <= 1'b0;
   endtask

   // no byte in flight and every pixel drained, plus a wait past the output register
   task automatic quiesce();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (exp_pending != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_directed(input int n);
      repeat (n) begin
         push_byte(DIRECTED_BYTES[dir_pos]);
         dir_pos++;
      end
   endtask

   function automatic logic [BYTE_W-1:0] pick_byte();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 8'h00;
      if (k == 1) return 8'hFF;
      return BYTE_W'($urandom_range(0, 255));
   endfunction

   initial begin
      int sent;
      int n;
      int k;
      int fmt;
      int w;
      int h;
      int bpp_eff;
      int w_eff;
      int h_eff;
      int pad;
      int img_bytes;
      logic [2:0] sel;

      reset = 1'b1;
      calm = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      csr_chan.valid = 1'b0;
      csr_chan.index = '0;
      csr_chan.data = '0;
      dir_pos = 0;
      cur_fmt = 3;
      cur_w = 1;
      cur_h = 1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset format: one bgr pixel and its padding byte
      send_directed(4);
      // format code zero and zero dimensions
      quiesce();
      program_regs(0, 0, 0, 3'b111);
      send_directed(4);
      // gray+alpha, two one-pixel rows, image end wraps
      quiesce();
      program_regs(2, 1, 2, 3'b111);
      send_directed(8);
      // format code above four, largest dimensions, stop mid pixel
      quiesce();
      program_regs(7, 65535, 65535, 3'b111);
      send_directed(6);
      // shorter format and width change with a pixel and column already past the end
      quiesce();
      program_regs(2, 1, 1, 3'b111);
      send_directed(3);

      sent = 0;
      while (sent < 1500) begin
         calm = (sent > 1200);
         k = $urandom_range(0, 9);
         if (k < 8) fmt = $urandom_range(1, 4);
         else if (k == 8) fmt = 0;
         else fmt = $urandom_range(5, 7);
         k = $urandom_range(0, 19);
         if (k <= 14) w = $urandom_range(1, 6);
         else if (k == 15) w = 0;
         else if (k == 16) w = 65535;
         else if (k == 17) w = $urandom_range(7, 40);
         else w = $urandom_range(0, 65535);
         k = $urandom_range(0, 19);
         if (k <= 15) h = $urandom_range(1, 3);
         else if (k == 16) h = 0;
         else if (k == 17) h = 65535;
         else h = $urandom_range(0, 65535);
         sel = ($urandom_range(0, 1) == 0) ? 3'b111 : 3'($urandom_range(1, 7));
         quiesce();
         program_regs(fmt, w, h, sel);

         bpp_eff = (cur_fmt == 0) ? 1 : ((cur_fmt > 4) ? 4 : cur_fmt);
         w_eff = (cur_w == 0) ? 1 : cur_w;
         h_eff = (cur_h == 0) ? 1 : cur_h;
         pad = (4 - ((w_eff % 4) * bpp_eff) % 4) % 4;
         img_bytes = (w_eff * bpp_eff + pad) * h_eff;
         if (w_eff <= 40 && h_eff <= 3 && $urandom_range(0, 3) != 0) begin
            n = img_bytes * $urandom_range(1, 2);
         end else begin
            n = $urandom_range(1, 40);
         end
         repeat (n) push_byte(pick_byte());
         sent += n;
      end

      quiesce();
      repeat (16) @(posedge clock);
      if (fail_count == 0) begin
         $display("bmp_pixel_row_unpacker test passed");
      end else begin
         $display("bmp_pixel_row_unpacker test failed");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/bpru_pkg.sv
rtl/bpru_if.sv
rtl/bmp_pixel_row_unpacker.sv
dv/bpru_pixel_checker.sv
dv/tb_bmp_pixel_row_unpacker.sv
